/* rtl/evf_pkg.sv */
// ----------------------------------------------------------------------------
// evf_pkg
// Shared types and constants of the VLAN / APPID frame filter.
// ----------------------------------------------------------------------------
`default_nettype none

package evf_pkg;

   // Result status codes
   localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STATUS_FILTERED  = 3'd1;
   localparam logic [2:0] STATUS_SHORT_HDR = 3'd2;
   localparam logic [2:0] STATUS_SHORT_TAG = 3'd3;
   localparam logic [2:0] STATUS_NO_APPID  = 3'd4;

   // Register indexes of the CSR write port
   localparam logic [2:0] CSR_DEST_MAC       = 3'd0;
   localparam logic [2:0] CSR_ETHER_TYPE     = 3'd1;
   localparam logic [2:0] CSR_EXPECT_TAGGED  = 3'd2;
   localparam logic [2:0] CSR_VLAN_ID        = 3'd3;
   localparam logic [2:0] CSR_CHECK_PRIORITY = 3'd4;
   localparam logic [2:0] CSR_PRIORITY       = 3'd5;
   localparam logic [2:0] CSR_APP_ID         = 3'd6;

   // Tag protocol identifiers
   localparam logic [15:0] TPID_Q  = 16'h8100;
   localparam logic [15:0] TPID_AD = 16'h88A8;

   // Byte positions within the frame header
   localparam int POS_SRC     = 6;
   localparam int POS_TYPE    = 12;
   localparam int POS_TCI     = 14;
   localparam int POS_INNER   = 16;
   localparam int POS_APP_TAG = 18;
   localparam int POS_APP_END = 20;

   // Header sizes and limits
   localparam int UNTAGGED_HDR = 14;
   localparam int TAGGED_HDR   = 18;
   localparam int APPID_BYTES  = 2;
   localparam int PLEN_W       = 14;
   localparam int PAYLEN_MAX   = 16383;
   localparam int WIDE_W       = 17;

   localparam logic [11:0] VID_MASK    = 12'h0FFF;
   localparam int          PRIO_SHIFT  = 13;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [15:0]       ether_type;
      logic [15:0]       app_id;
      logic              vlan_tagged;
      logic [11:0]       vlan_id;
      logic [2:0]        vlan_priority;
      logic [47:0]       source_mac;
      logic [4:0]        payload_offset;
      logic [PLEN_W-1:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [47:0] match_dest_mac;
      logic [15:0] match_ether_type;
      logic        expect_tagged;
      logic [11:0] match_vlan_id;
      logic        check_priority;
      logic [2:0]  match_priority;
      logic [15:0] match_app_id;
   } cfg_type;

   // Header fields of one frame, handed from parser to filter
   typedef struct packed {
      logic        dest_mismatch;
      logic [15:0] outer_type;
      logic [15:0] tag_control;
      logic [15:0] inner_type;
      logic [15:0] app_word;
      logic [47:0] source_mac;
   } frame_hdr_type;

   function automatic logic is_vlan_tpid(input logic [15:0] tpid);
      return (tpid == TPID_Q) || (tpid == TPID_AD);
   endfunction

endpackage

`default_nettype wire

/* rtl/evf_front.sv */
// ----------------------------------------------------------------------------
// evf_front
// Byte parser: checks the destination MAC, captures header fields and hands
// one header record per frame to the queue on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module evf_front #(
   parameter int LENGTH_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  evf_pkg::req_type          req_data,
   input  logic [47:0]               match_dest_mac,
   input  logic                      queue_full,
   output logic                      push_valid,
   output evf_pkg::frame_hdr_type    push_hdr,
   output logic [LENGTH_BITS-1:0]    push_len
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   mismatch_ff, mismatch_in;
   logic [15:0]            outer_ff, outer_in;
   logic [15:0]            tci_ff, tci_in;
   logic [15:0]            inner_ff, inner_in;
   logic [15:0]            app_ff, app_in;
   logic [47:0]            src_ff, src_in;
   logic [7:0]             want_byte;
   logic [7:0]             b;
   logic                   accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;

   // Select the expected destination byte, first byte most significant
   always_comb begin
      case (count_ff[2:0])
         3'd0:    want_byte = match_dest_mac[47:40];
         3'd1:    want_byte = match_dest_mac[39:32];
         3'd2:    want_byte = match_dest_mac[31:24];
         3'd3:    want_byte = match_dest_mac[23:16];
         3'd4:    want_byte = match_dest_mac[15:8];
         3'd5:    want_byte = match_dest_mac[7:0];
         default: want_byte = 8'h00;
      endcase
   end

   // Capture the byte into the field its position belongs to
   always_comb begin
      mismatch_in = mismatch_ff;
      outer_in    = outer_ff;
      tci_in      = tci_ff;
      inner_in    = inner_ff;
      app_in      = app_ff;
      src_in      = src_ff;
      if (count_ff < LENGTH_BITS'(evf_pkg::POS_SRC)) begin
         if (want_byte != b) mismatch_in = 1'b1;
      end else if (count_ff < LENGTH_BITS'(evf_pkg::POS_TYPE)) begin
         src_in = {src_ff[39:0], b};
      end else if (count_ff < LENGTH_BITS'(evf_pkg::POS_TCI)) begin
         outer_in = {outer_ff[7:0], b};
      end else if (count_ff < LENGTH_BITS'(evf_pkg::POS_INNER)) begin
         tci_in = {tci_ff[7:0], b};
         if (!evf_pkg::is_vlan_tpid(outer_ff)) app_in = {app_ff[7:0], b};
      end else if (count_ff < LENGTH_BITS'(evf_pkg::POS_APP_TAG)) begin
         inner_in = {inner_ff[7:0], b};
      end else if (count_ff < LENGTH_BITS'(evf_pkg::POS_APP_END)) begin
         if (evf_pkg::is_vlan_tpid(outer_ff)) app_in = {app_ff[7:0], b};
      end
      count_in = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   // Hand the completed header to the queue on the last beat
   always_comb begin
      push_valid           = accept && req_data.last_byte;
      push_len             = count_in;
      push_hdr.dest_mismatch = mismatch_in;
      push_hdr.outer_type  = outer_in;
      push_hdr.tag_control = tci_in;
      push_hdr.inner_type  = inner_in;
      push_hdr.app_word    = app_in;
      push_hdr.source_mac  = src_in;
   end

   // Advance on each beat, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_byte)) begin
         count_ff    <= '0;
         mismatch_ff <= 1'b0;
         outer_ff    <= '0;
         tci_ff      <= '0;
         inner_ff    <= '0;
         app_ff      <= '0;
         src_ff      <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         mismatch_ff <= mismatch_in;
         outer_ff    <= outer_in;
         tci_ff      <= tci_in;
         inner_ff    <= inner_in;
         app_ff      <= app_in;
         src_ff      <= src_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/evf_queue.sv */
// ----------------------------------------------------------------------------
// evf_queue
// Two-entry queue of frame header records between parser and filter.
// ----------------------------------------------------------------------------
`default_nettype none

module evf_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   // Track fill level and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

/* rtl/evf_back.sv */
// ----------------------------------------------------------------------------
// evf_back
// Filter stage: judges one header record against the configuration and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module evf_back #(
   parameter int LENGTH_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_valid,
   input  evf_pkg::frame_hdr_type    queue_hdr,
   input  logic [LENGTH_BITS-1:0]    queue_len,
   input  evf_pkg::cfg_type          cfg,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output evf_pkg::rsp_type          rsp_data
);

   logic                      rsp_valid_ff;
   evf_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      load;
   logic                      is_tagged;
   logic [11:0]               vid;
   logic [2:0]                prio;
   logic [15:0]               ptype;
   logic [4:0]                offset;
   logic [LENGTH_BITS-1:0]    min_app_len;
   logic [LENGTH_BITS-1:0]    plen_full;
   logic [evf_pkg::WIDE_W-1:0] plen_wide;
   logic                      hdr_mismatch;
   logic [2:0]                status;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign queue_pop = queue_valid && load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decode tag and payload position
   always_comb begin
      is_tagged = evf_pkg::is_vlan_tpid(queue_hdr.outer_type);
      if (is_tagged) begin
         vid         = queue_hdr.tag_control[11:0] & evf_pkg::VID_MASK;
         prio        = queue_hdr.tag_control[evf_pkg::PRIO_SHIFT +: 3];
         ptype       = queue_hdr.inner_type;
         offset      = 5'(evf_pkg::TAGGED_HDR);
         min_app_len = LENGTH_BITS'(evf_pkg::TAGGED_HDR + evf_pkg::APPID_BYTES);
      end else begin
         vid         = '0;
         prio        = '0;
         ptype       = queue_hdr.outer_type;
         offset      = 5'(evf_pkg::UNTAGGED_HDR);
         min_app_len = LENGTH_BITS'(evf_pkg::UNTAGGED_HDR + evf_pkg::APPID_BYTES);
      end
      hdr_mismatch = (ptype != cfg.match_ether_type) ||
                     (cfg.expect_tagged != is_tagged) ||
                     (is_tagged && (vid != cfg.match_vlan_id)) ||
                     (is_tagged && cfg.check_priority && (prio != cfg.match_priority));
   end

   // Rank the checks: header length first, then addressing, tag length, fields and APPID
   always_comb begin
      if (queue_len < LENGTH_BITS'(evf_pkg::UNTAGGED_HDR)) begin
         status = evf_pkg::STATUS_SHORT_HDR;
      end else if (queue_hdr.dest_mismatch) begin
         status = evf_pkg::STATUS_FILTERED;
      end else if (is_tagged && (queue_len < LENGTH_BITS'(evf_pkg::TAGGED_HDR))) begin
         status = evf_pkg::STATUS_SHORT_TAG;
      end else if (hdr_mismatch) begin
         status = evf_pkg::STATUS_FILTERED;
      end else if (queue_len < min_app_len) begin
         status = evf_pkg::STATUS_NO_APPID;
      end else if (queue_hdr.app_word != cfg.match_app_id) begin
         status = evf_pkg::STATUS_FILTERED;
      end else begin
         status = evf_pkg::STATUS_ACCEPTED;
      end
   end

   // Build the result, zero fields unless accepted
   always_comb begin
      plen_full = queue_len - LENGTH_BITS'(offset);
      plen_wide = evf_pkg::WIDE_W'(plen_full);
      rsp_in    = '0;
      rsp_in.status = status;
      if (status == evf_pkg::STATUS_ACCEPTED) begin
         rsp_in.ether_type     = ptype;
         rsp_in.app_id         = queue_hdr.app_word;
         rsp_in.vlan_tagged    = is_tagged;
         rsp_in.vlan_id        = vid;
         rsp_in.vlan_priority  = prio;
         rsp_in.source_mac     = queue_hdr.source_mac;
         rsp_in.payload_offset = offset;
         if (plen_wide > evf_pkg::WIDE_W'(evf_pkg::PAYLEN_MAX)) begin
            rsp_in.payload_length = evf_pkg::PLEN_W'(evf_pkg::PAYLEN_MAX);
         end else begin
            rsp_in.payload_length = evf_pkg::PLEN_W'(plen_wide);
         end
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= queue_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

/* rtl/ethernet_vlan_appid_frame_filter.sv */
// ----------------------------------------------------------------------------
// ethernet_vlan_appid_frame_filter
// Ethernet 802.1Q/802.1AD header parser with destination MAC and APPID
// filter; one status result per frame.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  req_      in    req_valid/req_ready  req_data  (data byte, last mark)
//  rsp_      out   rsp_valid/rsp_ready  rsp_data  (status and header fields)
//  csr_      in    csr_we               csr_index, csr_wdata
//
//  Takes one byte per cycle while req_ready is high. At the edge that accepts
//  the last byte of a frame, the parser pushes its header record into a
//  two-entry queue; the filter stage then judges it into the output register
//  once that register is empty or its result is taken.
//  Reset clears the parser, the queue, the output valid and the configuration.
//  A stalled output fills the queue; req_ready drops only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_vlan_appid_frame_filter #(
   parameter int LENGTH_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  evf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output evf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [47:0]      csr_wdata
);

   localparam int HDR_W   = $bits(evf_pkg::frame_hdr_type);
   localparam int QUEUE_W = LENGTH_BITS + HDR_W;

   evf_pkg::cfg_type        cfg_ff;
   logic                    q_push_valid;
   evf_pkg::frame_hdr_type  q_push_hdr;
   logic [LENGTH_BITS-1:0]  q_push_len;
   logic [QUEUE_W-1:0]      q_push_data;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_pop_valid;
   logic [QUEUE_W-1:0]      q_pop_data;
   evf_pkg::frame_hdr_type  q_pop_hdr;
   logic [LENGTH_BITS-1:0]  q_pop_len;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            evf_pkg::CSR_DEST_MAC:       cfg_ff.match_dest_mac   <= csr_wdata;
            evf_pkg::CSR_ETHER_TYPE:     cfg_ff.match_ether_type <= csr_wdata[15:0];
            evf_pkg::CSR_EXPECT_TAGGED:  cfg_ff.expect_tagged    <= csr_wdata[0];
            evf_pkg::CSR_VLAN_ID:        cfg_ff.match_vlan_id    <= csr_wdata[11:0];
            evf_pkg::CSR_CHECK_PRIORITY: cfg_ff.check_priority   <= csr_wdata[0];
            evf_pkg::CSR_PRIORITY:       cfg_ff.match_priority   <= csr_wdata[2:0];
            evf_pkg::CSR_APP_ID:         cfg_ff.match_app_id     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   evf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .match_dest_mac (cfg_ff.match_dest_mac),
      .queue_full     (q_full),
      .push_valid     (q_push_valid),
      .push_hdr       (q_push_hdr),
      .push_len       (q_push_len)
   );

   assign q_push_data = {q_push_len, q_push_hdr};

   evf_queue #(.WIDTH(QUEUE_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data)
   );

   assign q_pop_hdr = q_pop_data[HDR_W-1:0];
   assign q_pop_len = q_pop_data[QUEUE_W-1:HDR_W];

   evf_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (q_pop_valid),
      .queue_hdr   (q_pop_hdr),
      .queue_len   (q_pop_len),
      .cfg         (cfg_ff),
      .queue_pop   (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // No header record is pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push_valid |-> !q_full)
      else $error("header record pushed into full queue");

   // An accepted frame carries an offset that agrees with its tag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == evf_pkg::STATUS_ACCEPTED)) |->
      ((rsp_data.vlan_tagged && (rsp_data.payload_offset == 5'd18)) ||
       (!rsp_data.vlan_tagged && (rsp_data.payload_offset == 5'd14))))
      else $error("payload offset does not match tag presence");

   // A rejected frame reports no header fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != evf_pkg::STATUS_ACCEPTED)) |->
      ((rsp_data.source_mac == '0) && (rsp_data.ether_type == '0) &&
       (rsp_data.payload_offset == '0) && (rsp_data.payload_length == '0)))
      else $error("rejected frame carries header fields");

   // The output is empty right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire
